/* src/nsr_pkg.sv */
// ----------------------------------------------------------------------------
// nsr_pkg: shared constants and types for the Newton square root block
// Field widths, fixed limits, register map and the divider status struct.
// ----------------------------------------------------------------------------
package nsr_pkg;

  localparam int VALUE_W       = 56;
  localparam int ROOT_W        = 40;
  localparam int STEP_W        = 7;
  localparam int TOL_W         = 16;
  localparam int EST_W         = 62;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;
  localparam int TDATA_OUT_W   = 48;

  localparam int MAX_STEPS_DEF = 64;
  localparam int FRAC_BITS_DEF = 24;

  localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(17);
  localparam logic [EST_W-1:0]  QUOT_MAX  = {EST_W{1'b1}};
  localparam logic [ROOT_W-1:0] ROOT_MAX  = {ROOT_W{1'b1}};

  localparam logic REG_TOLERANCE = 1'b0;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

endpackage

/* src/newton_square_root_top.sv */
// ----------------------------------------------------------------------------
// newton_square_root_top: Newton-Raphson square root, Q32.24 in, Q16.24 out
// Sequencer around one shared divider, with output register and config port.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries the radicand; one transfer starts one computation and
//   s_tready stays low until the sequencer is idle again.
//   m_tdata carries the root and step count, m_tuser the cap flag.
//   Each Newton step passes through the compare state and the divide state:
//   the bit-serial divider takes one dividend bit per cycle, and the
//   sequencer takes its quotient when the divider signals done.
//   A zero radicand skips the steps and goes straight to the output.
//   The result sits in an output register; a new item is accepted while it
//   waits. If the receiver stalls, a finished second result holds in the
//   sequencer until the register frees.
//   The tolerance register lies at address 0 of the APB port; write it only
//   while the block is idle.
//   Reset is synchronous: it clears the sequencer, drops m_tvalid and sets
//   tolerance back to 17.
// ----------------------------------------------------------------------------
module newton_square_root_top #(
  parameter int MAX_STEPS = nsr_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // s_tdata: value[55:0]
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [nsr_pkg::VALUE_W-1:0]        s_tdata,
  // m_tdata: root[39:0], step_count[46:40], zero[47]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [nsr_pkg::TDATA_OUT_W-1:0]    m_tdata,
  // m_tuser: capped[0]
  output logic                               m_tuser,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nsr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [nsr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [nsr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int STEP_CNT_W = $clog2(MAX_STEPS + 1);
  localparam logic [nsr_pkg::EST_W-1:0] EST_ONE = nsr_pkg::EST_W'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t                      state;
  logic [nsr_pkg::VALUE_W-1:0] x;
  logic [nsr_pkg::EST_W-1:0]   r;
  logic [nsr_pkg::EST_W-1:0]   last;
  logic [STEP_CNT_W-1:0]       steps;
  logic                        capped;

  logic [nsr_pkg::TOL_W-1:0]   tolerance;
  logic [nsr_pkg::EST_W-1:0]   diff;
  logic [nsr_pkg::EST_W-1:0]   quotient;
  logic [nsr_pkg::EST_W:0]     sum;
  logic [nsr_pkg::ROOT_W-1:0]  root_sat;
  logic                        div_start;
  nsr_pkg::div_stat_t          div_stat;
  logic                        out_free;

  logic [nsr_pkg::ROOT_W-1:0]  out_root;
  logic [nsr_pkg::STEP_W-1:0]  out_steps;

  nsr_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .tolerance (tolerance)
  );

  nsr_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({x, {FRAC_BITS{1'b0}}}),
    .divisor  (r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign pready   = 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign diff      = (r >= last) ? (r - last) : (last - r);
  assign sum       = {1'b0, r} + {1'b0, quotient};
  assign root_sat  = (r > nsr_pkg::EST_W'(nsr_pkg::ROOT_MAX)) ? nsr_pkg::ROOT_MAX
                                                             : r[nsr_pkg::ROOT_W-1:0];
  assign div_start = (state == ST_CHECK) && !(diff < nsr_pkg::EST_W'(tolerance))
                     && !(steps >= STEP_CNT_W'(MAX_STEPS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= (s_tdata == '0) ? ST_FINISH : ST_CHECK;
          end
        end
        ST_CHECK: begin
          state <= div_start ? ST_DIV : ST_FINISH;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_CHECK;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          x      <= s_tdata;
          r      <= (s_tdata == '0) ? '0 : EST_ONE;
          last   <= '0;
          steps  <= '0;
          capped <= 1'b0;
        end
      end
      ST_CHECK: begin
        if (div_start) begin
          last <= r;
        end else if (!(diff < nsr_pkg::EST_W'(tolerance))) begin
          capped <= 1'b1;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          r     <= sum[nsr_pkg::EST_W:1];
          steps <= steps + STEP_CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      out_root  <= root_sat;
      out_steps <= nsr_pkg::STEP_W'(steps);
      m_tuser   <= capped;
    end
  end

  assign m_tdata = {1'b0, out_steps, out_root};

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_steps <= nsr_pkg::STEP_W'(MAX_STEPS)))
    else $error("step count above cap");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (out_steps == nsr_pkg::STEP_W'(MAX_STEPS)))
    else $error("capped result without full step count");

  assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider finished outside divide state");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) && div_stat.done |=> (state == ST_CHECK) && (steps != '0))
    else $error("step not counted after divide");

endmodule

/* src/nsr_regs.sv */
// ----------------------------------------------------------------------------
// nsr_regs: configuration register file
// APB-style write and read of the tolerance register.
// ----------------------------------------------------------------------------
module nsr_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nsr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [nsr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [nsr_pkg::APB_DATA_W-1:0]    prdata,
  output logic [nsr_pkg::TOL_W-1:0]         tolerance
);

  logic wr_en;
  logic reg_idx;

  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= nsr_pkg::TOL_RESET;
    end else if (wr_en && (reg_idx == nsr_pkg::REG_TOLERANCE)) begin
      tolerance <= pwdata[nsr_pkg::TOL_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      nsr_pkg::REG_TOLERANCE: prdata = nsr_pkg::APB_DATA_W'(tolerance);
      default:                prdata = '0;
    endcase
  end

endmodule

/* src/nsr_div.sv */
// ----------------------------------------------------------------------------
// nsr_div: shared restoring divider
// One quotient bit per cycle; saturates when the quotient needs more bits.
// ----------------------------------------------------------------------------
module nsr_div #(
  parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [nsr_pkg::VALUE_W+FRAC_BITS-1:0]     dividend,
  input  logic [nsr_pkg::EST_W-1:0]                 divisor,
  output logic [nsr_pkg::EST_W-1:0]                 quotient,
  output nsr_pkg::div_stat_t                        stat
);

  localparam int DIV_W = nsr_pkg::VALUE_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0]          dvd;
  logic [nsr_pkg::EST_W-1:0] dsr;
  logic [nsr_pkg::EST_W-1:0] rem;
  logic [nsr_pkg::EST_W-1:0] quo;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      done;
  logic                      sat;

  logic [nsr_pkg::EST_W:0]   trial;
  logic [nsr_pkg::EST_W:0]   trial_diff;
  logic                      bit_set;

  assign trial      = {rem, dvd[DIV_W-1]};
  assign trial_diff = trial - {1'b0, dsr};
  assign bit_set    = !trial_diff[nsr_pkg::EST_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= (divisor == '0) ? nsr_pkg::EST_W'(1) : divisor;
      rem <= '0;
      quo <= '0;
      sat <= 1'b0;
      cnt <= CNT_W'(DIV_W - 1);
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= bit_set ? trial_diff[nsr_pkg::EST_W-1:0] : trial[nsr_pkg::EST_W-1:0];
      quo <= {quo[nsr_pkg::EST_W-2:0], bit_set};
      if (bit_set && (cnt >= CNT_W'(nsr_pkg::EST_W))) begin
        sat <= 1'b1;
      end
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign quotient  = sat ? nsr_pkg::QUOT_MAX : quo;
  assign stat.done = done;
  assign stat.sat  = sat;

endmodule
